### sv/ico_pkg.sv
package ico_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XW           = 56;   // CORDIC vector width
  localparam int AW           = 36;   // CORDIC angle accumulator, Q2.30 plus headroom
  localparam int GYRO_Q_W     = 45;   // gyro increment magnitude width
  localparam int PROD_W       = 66;   // shared multiplier product width

  localparam logic [4:0]           CORDIC_LAST = 5'(CORDIC_STEPS - 1);
  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [31:0]   PI_Q16      = 32'sd205887;
  // ceil(2^72 / 15625): exact floor division by 15625 for any 58-bit dividend
  localparam logic [58:0]          US_RECIP    = 59'd302231454903657294;
  localparam logic [63:0]          HALF_US     = 64'd500000;
  localparam logic [15:0]          WEIGHT_RST  = 16'd64225;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_GMUL   = 15'h0002,
    ST_GDIV   = 15'h0004,
    ST_GACC   = 15'h0008,
    ST_AM1    = 15'h0010,
    ST_AM2    = 15'h0020,
    ST_AM3    = 15'h0040,
    ST_SQRT   = 15'h0080,
    ST_CROLL  = 15'h0100,
    ST_CPITCH = 15'h0200,
    ST_BM1    = 15'h0400,
    ST_BM2    = 15'h0800,
    ST_BM3    = 15'h1000,
    ST_BFIN   = 15'h2000,
    ST_DONE   = 15'h4000
  } state_t;

  function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    unique case (idx)
      5'd0:    v = 36'sd843314857;
      5'd1:    v = 36'sd497837829;
      5'd2:    v = 36'sd263043837;
      5'd3:    v = 36'sd133525159;
      5'd4:    v = 36'sd67021687;
      5'd5:    v = 36'sd33543516;
      5'd6:    v = 36'sd16775851;
      5'd7:    v = 36'sd8388437;
      5'd8:    v = 36'sd4194283;
      5'd9:    v = 36'sd2097149;
      5'd10:   v = 36'sd1048576;
      5'd11:   v = 36'sd524288;
      5'd12:   v = 36'sd262144;
      5'd13:   v = 36'sd131072;
      5'd14:   v = 36'sd65536;
      5'd15:   v = 36'sd32768;
      5'd16:   v = 36'sd16384;
      5'd17:   v = 36'sd8192;
      5'd18:   v = 36'sd4096;
      5'd19:   v = 36'sd2048;
      5'd20:   v = 36'sd1024;
      5'd21:   v = 36'sd512;
      5'd22:   v = 36'sd256;
      5'd23:   v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/ico_if.sv
interface ico_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] sample_z;
  logic [31:0]        stamp_us;
  modport source(output valid, action, sample_x, sample_y, sample_z, stamp_us, input ready);
  modport sink(input valid, action, sample_x, sample_y, sample_z, stamp_us, output ready);
endinterface

interface ico_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_x;
  logic signed [31:0] angle_y;
  logic signed [31:0] angle_z;
  logic               initialized;
  modport source(output valid, angle_x, angle_y, angle_z, initialized, input ready);
  modport sink(input valid, angle_x, angle_y, angle_z, initialized, output ready);
endinterface

interface ico_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] blend_weight;
  modport source(output valid, blend_weight, input ready);
  modport sink(input valid, blend_weight, output ready);
endinterface

### sv/ico_cdiv.sv
module ico_cdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [63:0]                   num,
  output logic                          done,
  output logic [ico_pkg::GYRO_Q_W-1:0]  quo
);
  import ico_pkg::*;

  logic         busy_r;
  logic         done_r;
  logic [1:0]   cnt_r;
  logic [57:0]  x_r;
  logic [116:0] acc_r;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [63:0]  part_p;
  logic [116:0] part_s;

  // num / 10^6 = (num / 64) / 15625; multiply by the reciprocal in four
  // 32x32 partial products and keep the bits above 2^72
  assign op_a   = cnt_r[1] ? {6'd0, x_r[57:32]} : x_r[31:0];
  assign op_b   = cnt_r[0] ? {5'd0, US_RECIP[58:32]} : US_RECIP[31:0];
  assign part_p = op_a * op_b;

  always_comb begin
    if (cnt_r == 2'd0) begin
      part_s = {53'd0, part_p};
    end else if (cnt_r == 2'd3) begin
      part_s = {part_p[52:0], 64'd0};
    end else begin
      part_s = {21'd0, part_p, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= num[63:6];
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_r + part_s;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = acc_r[72 +: GYRO_Q_W];

endmodule

### sv/ico_isqrt.sv
module ico_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);
  import ico_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] s;

  assign s = res_r + bit_r;

  // one result bit a cycle, digit pairs from the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        n_r    <= n;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        if (n_r >= s) begin
          n_r   <= n_r - s;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

### sv/ico_cordic.sv
module ico_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic signed [31:0] angle
);
  import ico_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           i_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [AW-1:0] ang_r;
  logic signed [31:0]   res_r;

  logic signed [XW-1:0] ae;
  logic signed [XW-1:0] be;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [AW-1:0] step;
  logic signed [AW-1:0] ang_nxt;
  logic signed [AW-1:0] ang_rnd;

  assign ae = {{(XW-33){a[32]}}, a};
  assign be = {{(XW-33){b[32]}}, b};
  // fold the left half plane onto the right one, pi signed by a is added back below
  assign x0 = (b[32] ? -be : be) <<< 20;
  assign y0 = (b[32] ? -ae : ae) <<< 20;

  assign xs      = x_r >>> i_r;
  assign ys      = y_r >>> i_r;
  assign step    = atan_q30(i_r);
  assign ang_nxt = y_r[XW-1] ? ang_r - step : ang_r + step;
  assign ang_rnd = ang_nxt + 36'sd8192;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        if (a == '0 && b == '0) begin
          res_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          i_r    <= '0;
          x_r    <= x0;
          y_r    <= y0;
          if (b[32]) begin
            ang_r <= a[32] ? -PI_Q30 : PI_Q30;
          end else begin
            ang_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r[XW-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
        end
        ang_r <= ang_nxt;
        i_r   <= i_r + 5'd1;
        if (i_r == CORDIC_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= {{(32-(AW-14)){ang_rnd[AW-1]}}, ang_rnd[AW-1:14]};
        end
      end
    end
  end

  assign done  = done_r;
  assign angle = res_r;

endmodule

### sv/imu_complementary_orientation.sv
// A gyro transaction runs per axis: one multiply, the four-step reciprocal multiply that
// divides by one million, then one accumulate; after the third axis the output is loaded.
// A later accelerometer transaction runs the square root, a CORDIC atan2 for roll and one
// for pitch, then the two blends; the first accelerometer transaction skips the blends.
// A gyro transaction before the first accelerometer one only records the stamp.
// One transaction at a time; a finished result waits in the output register.
// Synchronous active-low reset: angles zero, pose not initialized, blend weight 64225.
module imu_complementary_orientation (
  input logic       clk,
  input logic       rst_n,
  ico_in_if.sink    in_ch,
  ico_out_if.source out_ch,
  ico_cfg_if.sink   cfg_ch
);
  import ico_pkg::*;

  state_t             state_r;
  logic [15:0]        weight_r;
  logic               awaiting_r;
  logic [31:0]        prev_stamp_r;
  logic signed [31:0] orient_r [3];
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;
  logic signed [31:0] sz_r;
  logic [31:0]        d_r;
  logic [1:0]         axis_r;
  logic               sel_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [31:0] roll_r;
  logic signed [31:0] pitch_r;
  logic               div_go_r;
  logic               sq_go_r;
  logic               cord_go_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic signed [31:0] out_z_r;
  logic               out_init_r;

  logic                     in_fire;
  logic                     out_free;
  logic signed [31:0]       rate;
  logic signed [32:0]       rate_e;
  logic signed [32:0]       rate_mag;
  logic signed [32:0]       ay_mag;
  logic signed [32:0]       az_mag;
  logic signed [32:0]       ma;
  logic signed [32:0]       mb;
  logic signed [PROD_W-1:0] prod;
  logic                     div_done;
  logic [GYRO_Q_W-1:0]      quo;
  logic signed [PROD_W-1:0] gyro_old;
  logic signed [PROD_W-1:0] gyro_q;
  logic signed [PROD_W-1:0] gyro_new;
  logic                     sq_done;
  logic [31:0]              root;
  logic                     cord_done;
  logic signed [31:0]       cord_angle;
  logic signed [32:0]       cord_a;
  logic signed [32:0]       cord_b;
  logic signed [31:0]       blend_cur;
  logic signed [31:0]       blend_acc;
  logic signed [PROD_W-1:0] blend_rnd;
  logic [16:0]              weight_c;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = state_r == ST_IDLE;
  assign cfg_ch.ready = 1'b1;

  // axis 0 and 1 subtract the z and y rates, axis 2 adds the x rate
  always_comb begin
    case (axis_r)
      2'd0:    rate = sz_r;
      2'd1:    rate = sy_r;
      default: rate = sx_r;
    endcase
  end
  assign rate_e   = {rate[31], rate};
  assign rate_mag = rate[31] ? -rate_e : rate_e;
  assign ay_mag   = sy_r[31] ? -{sy_r[31], sy_r} : {sy_r[31], sy_r};
  assign az_mag   = sz_r[31] ? -{sz_r[31], sz_r} : {sz_r[31], sz_r};

  assign blend_cur = sel_r ? orient_r[2] : orient_r[0];
  assign blend_acc = sel_r ? roll_r : pitch_r;
  assign weight_c  = 17'd65536 - {1'b0, weight_r};

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_GMUL: begin
        ma = rate_mag;
        mb = {1'b0, d_r};
      end
      ST_AM1: begin
        ma = ay_mag;
        mb = ay_mag;
      end
      ST_AM2: begin
        ma = az_mag;
        mb = az_mag;
      end
      ST_BM1: begin
        ma = {blend_cur[31], blend_cur};
        mb = {17'd0, weight_r};
      end
      ST_BM2: begin
        ma = {blend_acc[31], blend_acc};
        mb = {16'd0, weight_c};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign prod = ma * mb;

  assign gyro_old = {{(PROD_W-32){orient_r[axis_r][31]}}, orient_r[axis_r]};
  assign gyro_q   = {{(PROD_W-GYRO_Q_W){1'b0}}, quo};
  assign gyro_new = ((axis_r != 2'd2) ^ rate[31]) ? gyro_old - gyro_q : gyro_old + gyro_q;

  assign blend_rnd = (acc_r + 66'sd32768) >>> 16;

  assign cord_a = (state_r == ST_CPITCH) ? {sx_r[31], sx_r} : {sy_r[31], sy_r};
  assign cord_b = (state_r == ST_CPITCH) ? {1'b0, root} : {sz_r[31], sz_r};

  ico_cdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (prod_r[63:0] + HALF_US),
    .done  (div_done),
    .quo   (quo)
  );

  ico_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sq_go_r),
    .n     (acc_r[63:0]),
    .done  (sq_done),
    .root  (root)
  );

  ico_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cord_go_r),
    .a     (cord_a),
    .b     (cord_b),
    .done  (cord_done),
    .angle (cord_angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      weight_r     <= WEIGHT_RST;
      awaiting_r   <= 1'b1;
      prev_stamp_r <= '0;
      orient_r[0]  <= '0;
      orient_r[1]  <= '0;
      orient_r[2]  <= '0;
      axis_r       <= '0;
      sel_r        <= 1'b0;
      div_go_r     <= 1'b0;
      sq_go_r      <= 1'b0;
      cord_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_go_r  <= 1'b0;
      sq_go_r   <= 1'b0;
      cord_go_r <= 1'b0;
      if (cfg_ch.valid) begin
        weight_r <= cfg_ch.blend_weight;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sx_r <= in_ch.sample_x;
            sy_r <= in_ch.sample_y;
            sz_r <= in_ch.sample_z;
            if (in_ch.action) begin
              state_r <= ST_AM1;
            end else begin
              d_r          <= in_ch.stamp_us - prev_stamp_r;
              prev_stamp_r <= in_ch.stamp_us;
              axis_r       <= '0;
              state_r      <= awaiting_r ? ST_DONE : ST_GMUL;
            end
          end
        end
        ST_GMUL: begin
          prod_r   <= prod;
          div_go_r <= 1'b1;
          state_r  <= ST_GDIV;
        end
        ST_GDIV: begin
          if (div_done) begin
            state_r <= ST_GACC;
          end
        end
        ST_GACC: begin
          orient_r[axis_r] <= sat32(gyro_new);
          if (axis_r == 2'd2) begin
            state_r <= ST_DONE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= ST_GMUL;
          end
        end
        ST_AM1: begin
          prod_r  <= prod;
          state_r <= ST_AM2;
        end
        ST_AM2: begin
          prod_r  <= prod;
          acc_r   <= prod_r;
          state_r <= ST_AM3;
        end
        ST_AM3: begin
          acc_r   <= acc_r + prod_r;
          sq_go_r <= 1'b1;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_done) begin
            cord_go_r <= 1'b1;
            state_r   <= ST_CROLL;
          end
        end
        ST_CROLL: begin
          if (cord_done) begin
            roll_r    <= cord_angle;
            cord_go_r <= 1'b1;
            state_r   <= ST_CPITCH;
          end
        end
        ST_CPITCH: begin
          if (cord_done) begin
            pitch_r <= cord_angle;
            if (awaiting_r) begin
              awaiting_r  <= 1'b0;
              orient_r[0] <= cord_angle;
              orient_r[1] <= PI_Q16;
              orient_r[2] <= roll_r;
              state_r     <= ST_DONE;
            end else begin
              sel_r   <= 1'b0;
              state_r <= ST_BM1;
            end
          end
        end
        ST_BM1: begin
          prod_r  <= prod;
          state_r <= ST_BM2;
        end
        ST_BM2: begin
          prod_r  <= prod;
          acc_r   <= prod_r;
          state_r <= ST_BM3;
        end
        ST_BM3: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_BFIN;
        end
        ST_BFIN: begin
          if (sel_r) begin
            orient_r[2] <= sat32(blend_rnd);
            state_r     <= ST_DONE;
          end else begin
            orient_r[0] <= sat32(blend_rnd);
            sel_r       <= 1'b1;
            state_r     <= ST_BM1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= orient_r[0];
            out_y_r     <= orient_r[1];
            out_z_r     <= orient_r[2];
            out_init_r  <= !awaiting_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.angle_x     = out_x_r;
  assign out_ch.angle_y     = out_y_r;
  assign out_ch.angle_z     = out_z_r;
  assign out_ch.initialized = out_init_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted twice without finishing");

  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |=> !awaiting_r)
    else $error("pose lost its initialized flag");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_SQRT)
    else $error("square root finished outside its state");

  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == ST_CROLL || state_r == ST_CPITCH))
    else $error("atan2 finished outside its states");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_GDIV)
    else $error("divider finished outside its state");

endmodule

### tb/sv/ico_checker.sv
`timescale 1ns / 1ps

module ico_checker (
  input  logic clk,
  input  logic rst_n,
  ico_in_if    in_ch,
  ico_out_if   out_ch,
  ico_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import ico_pkg::*;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic               init;
  } pose_t;

  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  pose_t              pose_q[$];
  logic [15:0]        weight;
  logic               await_accel;
  logic [31:0]        last_stamp;
  logic signed [31:0] angle[3];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] cordic_atan2(input longint a, input longint b);
    longint x, y, acc, nx;
    acc = 0;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      acc = (a >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      a = -a;
      b = -b;
    end
    x = b <<< 20;
    y = a <<< 20;
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        acc = acc + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        acc = acc - ATAN_TAB[i];
      end
      x = nx;
    end
    acc = (acc + 8192) >>> 14;
    return acc[31:0];
  endfunction

  function automatic longint rate_delta(input longint rate, input logic [31:0] d);
    longint unsigned mag, q;
    mag = (rate < 0) ? longint'(-rate) : rate;
    q = (mag * {32'd0, d} + 64'd500000) / 64'd1000000;
    return (rate < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] mix(input logic signed [31:0] cur,
                                             input logic signed [31:0] acc_ang);
    longint s;
    s = longint'(cur) * longint'({1'b0, weight})
      + longint'(acc_ang) * (65536 - longint'({1'b0, weight})) + 32768;
    return clamp32(s >>> 16);
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic predict();
    longint sx, sy, sz;
    longint unsigned my, mz;
    longint r;
    logic signed [31:0] roll, pitch;
    pose_t p;
    sx = longint'(in_ch.sample_x);
    sy = longint'(in_ch.sample_y);
    sz = longint'(in_ch.sample_z);
    if (in_ch.action == 1'b0) begin
      if (!await_accel) begin
        angle[0] = clamp32(longint'(angle[0]) - rate_delta(sz, in_ch.stamp_us - last_stamp));
        angle[1] = clamp32(longint'(angle[1]) - rate_delta(sy, in_ch.stamp_us - last_stamp));
        angle[2] = clamp32(longint'(angle[2]) + rate_delta(sx, in_ch.stamp_us - last_stamp));
      end
      last_stamp = in_ch.stamp_us;
    end else begin
      my = (sy < 0) ? -sy : sy;
      mz = (sz < 0) ? -sz : sz;
      r = floor_sqrt(my * my + mz * mz);
      roll = cordic_atan2(sy, sz);
      pitch = cordic_atan2(sx, r);
      if (await_accel) begin
        await_accel = 1'b0;
        angle[0] = pitch;
        angle[1] = PI_Q16;
        angle[2] = roll;
      end else begin
        angle[0] = mix(angle[0], pitch);
        angle[2] = mix(angle[2], roll);
      end
    end
    p.ax = angle[0];
    p.ay = angle[1];
    p.az = angle[2];
    p.init = !await_accel;
    pose_q.push_back(p);
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      pose_q.delete();
      weight <= WEIGHT_RST;
      await_accel = 1'b1;
      last_stamp = '0;
      angle[0] = '0;
      angle[1] = '0;
      angle[2] = '0;
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict();
      if (cfg_ch.valid && cfg_ch.ready) weight <= cfg_ch.blend_weight;
      if (out_ch.valid && out_ch.ready) begin
        if (pose_q.size() == 0) begin
          report("unexpected result", out_ch.angle_x, 0);
        end else begin
          want = pose_q.pop_front();
          if (out_ch.angle_x !== want.ax) report("angle_x", out_ch.angle_x, want.ax);
          if (out_ch.angle_y !== want.ay) report("angle_y", out_ch.angle_y, want.ay);
          if (out_ch.angle_z !== want.az) report("angle_z", out_ch.angle_z, want.az);
          if (out_ch.initialized !== want.init)
            report("initialized", out_ch.initialized, want.init);
        end
      end
    end
    pending <= pose_q.size();
  end

endmodule

### tb/sv/imu_complementary_orientation_tb.sv
`timescale 1ns / 1ps

module imu_complementary_orientation_tb;

  localparam int STALL_LIMIT = 30000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   in_idle_pct;
  int   out_stall_pct;
  int   idle_cycles;
  logic hold_req;
  logic [31:0] stamp_now;

  ico_in_if  in_ch();
  ico_out_if out_ch();
  ico_cfg_if cfg_ch();

  imu_complementary_orientation u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ico_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      repeat (3000) @(negedge clk);
      hold_req <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send(input logic act, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [31:0] stamp);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.sample_x <= x;
    in_ch.sample_y <= y;
    in_ch.sample_z <= z;
    in_ch.stamp_us <= stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0 || hold_req) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_weight(input logic [15:0] w);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.blend_weight <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_items(input int n);
    logic [31:0] g;
    for (int i = 0; i < n; i++) begin
      g = $urandom_range(99);
      if (g < 10) begin
        // noise: arbitrary values and stamps
        stamp_now = $urandom();
        send(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), stamp_now);
      end else if (g < 45) begin
        send(1'b1, $signed($urandom_range(131072)) - 65536,
             $signed($urandom_range(131072)) - 65536,
             $signed($urandom_range(131072)) - 65536, $urandom());
      end else begin
        stamp_now = stamp_now + $urandom_range(20000);
        send(1'b0, $signed($urandom_range(400000)) - 200000,
             $signed($urandom_range(400000)) - 200000,
             $signed($urandom_range(400000)) - 200000, stamp_now);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    idle_cycles = 0;
    stamp_now = '0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    in_ch.stamp_us = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.blend_weight = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // gyro before first accel only records the stamp
    send(1'b0, 32'h7fffffff, 32'h80000000, 32'h12345678, 32'd1000);
    send(1'b0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd5000);
    // zero vector sets pose with zero pitch and roll
    send(1'b1, 32'd0, 32'd0, 32'd0, 32'hffffffff);
    send(1'b0, 32'd65536, 32'd65536, 32'd65536, 32'd15000);
    send(1'b1, 32'd65536, 32'd0, 32'hffff0000, 32'd0);
    send(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 32'd0);
    send(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd0);
    send(1'b1, 32'hffff0000, 32'h80000000, 32'd0, 32'd0);
    send(1'b1, 32'd0, 32'd0, 32'hffff0000, 32'd0);
    // wrapped stamp reads as a long elapsed time and saturates
    send(1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'd10);
    send(1'b0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'd9);
    send(1'b0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hfffffff0);
    send(1'b0, 32'd0, 32'd0, 32'd0, 32'd100);
    send(1'b0, 32'hffffffff, 32'd1, 32'hffffffff, 32'd100);
    send(1'b0, 32'hfff00000, 32'h00100000, 32'h55555555, 32'haaaaaaaa);
    send(1'b1, 32'd100, 32'hffffff00, 32'd200, 32'd0);
    stamp_now = 32'haaaaaaaa;
    drain();

    write_weight(16'd0);
    random_items(100);
    drain();

    write_weight(16'hffff);
    in_idle_pct = 49;
    random_items(300);
    drain();

    write_weight(16'($urandom()));
    in_idle_pct = 0;
    out_stall_pct = 49;
    random_items(300);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_weight(16'd32768);
    out_stall_pct = 0;
    @(negedge clk);
    hold_req <= 1'b1;
    random_items(100);
    drain();

    write_weight(16'd64225);
    in_idle_pct = 9;
    out_stall_pct = 9;
    random_items(400);
    drain();

    write_weight(16'($urandom()));
    in_idle_pct = 0;
    out_stall_pct = 0;
    random_items(300);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### imu_complementary_orientation.f
sv/ico_pkg.sv
sv/ico_if.sv
sv/ico_cdiv.sv
sv/ico_isqrt.sv
sv/ico_cordic.sv
sv/imu_complementary_orientation.sv
tb/sv/ico_checker.sv
tb/sv/imu_complementary_orientation_tb.sv
